### rtl/rsv_pkg.sv
// ----------------------------------------------------------------------------
// Release swipe velocity package
// Shared constants, codes and types for the release swipe velocity block.
// ----------------------------------------------------------------------------
package rsv_pkg;

  // Ring of recent touch frames.
  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Scaling: 65535 position units are one key length, Q8.8 per second.
  localparam logic [15:0] KEY_UNITS      = 16'd65535;
  localparam logic [27:0] Q88_PER_SECOND = 28'd256000000;

  // Divider operand widths: numerator is 65535 * 256e6 at most (44 bits),
  // denominator is 65535 * dt with a 32-bit dt (48 bits).
  localparam int NUM_W = 44;
  localparam int DEN_W = 48;
  localparam int CNT_W = $clog2(NUM_W + 1);

  // Input commands.
  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Gesture classes.
  localparam logic [1:0] GEST_NONE = 2'd0;
  localparam logic [1:0] GEST_UP   = 2'd1;
  localparam logic [1:0] GEST_DOWN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOOKBACK  = 2'd0;
  localparam logic [1:0] REG_UP_THR    = 2'd1;
  localparam logic [1:0] REG_DOWN_THR  = 2'd2;
  localparam logic [1:0] REG_SUSPENDED = 2'd3;

  // One stored touch frame.
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] pos;
    logic [1:0]  touches;
  } frame_t;

  // Divider result: truncated quotient and a flag for quotients of 32768 or more.
  typedef struct packed {
    logic [15:0] quot;
    logic        big;
  } div_res_t;

endpackage

### rtl/rsv_ring.sv
// ----------------------------------------------------------------------------
// Release swipe velocity frame ring
// Single-port-write, single-port-read memory of recent touch frames with a
// registered read.
// ----------------------------------------------------------------------------
module rsv_ring
  import rsv_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [RING_AW-1:0] waddr,
  input  frame_t             wdata,
  input  logic [RING_AW-1:0] raddr,
  output frame_t             rdata
);

  frame_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/rsv_div.sv
// ----------------------------------------------------------------------------
// Release swipe velocity divider
// Restoring divider producing one quotient bit per cycle, with the quotient
// kept to 16 bits and a sticky flag for larger results.
// ----------------------------------------------------------------------------
module rsv_div
  import rsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output div_res_t         res
);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] divisor;
  logic [NUM_W-1:0] numsh;
  logic [15:0]      quot;
  logic             ovf;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem[DEN_W-1:0], numsh[NUM_W-1]};
    fits     = rem_sh >= {1'b0, divisor};
    rem_next = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      numsh   <= num;
      quot    <= '0;
      ovf     <= 1'b0;
    end else if (active) begin
      rem   <= rem_next;
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      quot  <= {quot[14:0], fits};
      ovf   <= ovf | quot[15];
    end
  end

  assign res.quot = quot;
  assign res.big  = ovf | quot[15];

endmodule

### rtl/release_swipe_velocity.sv
// ----------------------------------------------------------------------------
// Release swipe velocity
// Stores touch frames in a ring and, on a key release, walks back through the
// recent frames to measure the swipe velocity and classify the gesture.
// ----------------------------------------------------------------------------
//
// Channel    Handshake                   Payload
// ---------  --------------------------  -------------------------------------
// items in   start & !busy               command, timestamp, touch_count,
//                                        position, note_active
// results    done, one cycle per result  velocity_valid, velocity, gesture
// config     APB write, pready always 1  lookback_limit, up_threshold,
//                                        down_threshold, output_suspended
//
// A frame item is written into the ring at the edge that accepts it, and busy
// stays low, so frames may arrive in every cycle while no release is in work.
// A release item with the note on walks back through the ring, each frame
// taking a memory read state and a check state, with one more read state when
// the walk runs off the oldest frame; then come the set-up states (difference,
// multiply, divider start), a wait on the serial divider, and the saturate and
// output states. A release on an empty ring goes straight to the output state,
// and one whose end and start frames share a timestamp skips the divider and
// goes from the difference state to the output state. A release with the note
// off is accepted and gives no result.
// Synchronous reset empties the ring (fill level and write slot to zero) and
// loads the register defaults; ring contents are not cleared, as the walk
// only ever reads entries that have been written. Results are presented for
// exactly one cycle with done and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module release_swipe_velocity
  import rsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Item channel
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [31:0]        timestamp,
  input  logic [1:0]         touch_count,
  input  logic [15:0]        position,
  input  logic               note_active,
  // Result channel
  output logic               done,
  output logic               velocity_valid,
  output logic signed [15:0] velocity,
  output logic [1:0]         gesture,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_WALK_RD = 9'b000000010,
    ST_WALK_CK = 9'b000000100,
    ST_DIFF    = 9'b000001000,
    ST_MUL     = 9'b000010000,
    ST_DIV_GO  = 9'b000100000,
    ST_DIV_WT  = 9'b001000000,
    ST_SAT     = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0]        lookback_limit;
  logic signed [15:0] up_threshold;
  logic signed [15:0] down_threshold;
  logic               output_suspended;

  // Ring bookkeeping.
  logic [RING_AW-1:0] write_slot;
  logic [FILL_W-1:0]  fill_level;
  logic [RING_AW-1:0] rd_slot;
  logic [FILL_W-1:0]  walk_idx;
  logic               seen;
  logic [31:0]        rel_stamp;

  // End and start points of the swipe, and the last frame checked.
  logic [31:0] end_stamp;
  logic [15:0] end_pos;
  logic [31:0] start_stamp;
  logic [15:0] start_pos;
  logic [31:0] prev_stamp;
  logic [15:0] prev_pos;

  // Arithmetic operands and the result under construction.
  logic               neg;
  logic [15:0]        mag;
  logic [31:0]        dt;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic               valid_r;
  logic signed [15:0] vel_r;

  frame_t   cur;
  frame_t   frame_in;
  logic     ring_we;
  logic     div_start;
  logic     div_done;
  div_res_t div_res;

  logic               item_acc;
  logic               cfg_wr;
  logic [31:0]        age;
  logic               too_old;
  logic [RING_AW-1:0] newest_slot;
  logic [RING_AW-1:0] prev_slot;
  logic [31:0]        dt_calc;
  logic [1:0]         gesture_calc;

  assign busy     = (state != ST_IDLE);
  assign item_acc = start && !busy;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // A frame item goes straight into the ring at the slot after the newest.
  assign ring_we            = item_acc && (command == CMD_FRAME);
  assign frame_in.stamp     = timestamp;
  assign frame_in.pos       = position;
  assign frame_in.touches   = touch_count;

  rsv_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (frame_in),
    .raddr (rd_slot),
    .rdata (cur)
  );

  assign div_start = (state == ST_DIV_GO);

  rsv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .res   (div_res)
  );

  // Slot arithmetic with wrap-around at the ring depth.
  always_comb begin
    newest_slot = (write_slot == '0) ? RING_AW'(RING_DEPTH - 1) : (write_slot - 1'b1);
    prev_slot   = (rd_slot == '0) ? RING_AW'(RING_DEPTH - 1) : (rd_slot - 1'b1);
  end

  // The age of the frame under test, modulo 2^32 like the timestamps.
  assign age     = rel_stamp - cur.stamp;
  assign too_old = (age >= lookback_limit);
  assign dt_calc = end_stamp - start_stamp;

  // Classification is done on the finished velocity; an invalid result and a
  // suspended output both report no gesture.
  always_comb begin
    gesture_calc = GEST_NONE;
    if (valid_r && !output_suspended) begin
      if (vel_r > up_threshold) begin
        gesture_calc = GEST_UP;
      end else if (vel_r < down_threshold) begin
        gesture_calc = GEST_DOWN;
      end
    end
  end

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      lookback_limit   <= 32'd100000;
      up_threshold     <= 16'sd256;
      down_threshold   <= -16'sd384;
      output_suspended <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOOKBACK:  lookback_limit   <= pwdata;
        REG_UP_THR:    up_threshold     <= $signed(pwdata[15:0]);
        REG_DOWN_THR:  down_threshold   <= $signed(pwdata[15:0]);
        REG_SUSPENDED: output_suspended <= pwdata[0];
        default:       lookback_limit   <= lookback_limit;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOOKBACK:  prdata = lookback_limit;
      REG_UP_THR:    prdata = {{16{up_threshold[15]}}, up_threshold};
      REG_DOWN_THR:  prdata = {{16{down_threshold[15]}}, down_threshold};
      REG_SUSPENDED: prdata = {31'd0, output_suspended};
      default:       prdata = '0;
    endcase
  end

  // Ring fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_level <= '0;
    end else if (ring_we) begin
      write_slot <= (write_slot == RING_AW'(RING_DEPTH - 1)) ? '0 : (write_slot + 1'b1);
      if (fill_level < FILL_W'(RING_DEPTH)) begin
        fill_level <= fill_level + 1'b1;
      end
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      walk_idx <= '0;
      seen     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_acc && (command == CMD_RELEASE) && note_active) begin
            walk_idx <= '0;
            seen     <= 1'b0;
            state    <= (fill_level == '0) ? ST_OUT : ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          // Running off the oldest frame ends the walk there.
          state <= (walk_idx == fill_level) ? ST_DIFF : ST_WALK_CK;
        end
        ST_WALK_CK: begin
          if (too_old) begin
            state <= ST_DIFF;
          end else if ((cur.touches == 2'd0) && seen) begin
            state <= ST_DIFF;
          end else begin
            if (cur.touches != 2'd0) begin
              seen <= 1'b1;
            end
            walk_idx <= walk_idx + 1'b1;
            state    <= ST_WALK_RD;
          end
        end
        ST_DIFF: begin
          state <= (dt_calc == '0) ? ST_OUT : ST_MUL;
        end
        ST_MUL:    state <= ST_DIV_GO;
        ST_DIV_GO: state <= ST_DIV_WT;
        ST_DIV_WT: begin
          if (div_done) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: state <= ST_OUT;
        ST_OUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rel_stamp <= timestamp;
        rd_slot   <= newest_slot;
        valid_r   <= 1'b0;
        vel_r     <= '0;
      end
      ST_WALK_RD: begin
        start_stamp <= prev_stamp;
        start_pos   <= prev_pos;
      end
      ST_WALK_CK: begin
        // The newest frame is the end point until a frame with touches is met.
        if ((walk_idx == '0) ||
            (!too_old && (cur.touches != 2'd0) && !seen)) begin
          end_stamp <= cur.stamp;
          end_pos   <= cur.pos;
        end
        if (too_old) begin
          start_stamp <= cur.stamp;
          start_pos   <= cur.pos;
        end else if ((cur.touches == 2'd0) && seen) begin
          // The frame just after the gap starts the swipe.
          start_stamp <= prev_stamp;
          start_pos   <= prev_pos;
        end
        prev_stamp <= cur.stamp;
        prev_pos   <= cur.pos;
        rd_slot    <= prev_slot;
      end
      ST_DIFF: begin
        dt  <= dt_calc;
        neg <= (end_pos < start_pos);
        mag <= (end_pos < start_pos) ? (start_pos - end_pos) : (end_pos - start_pos);
      end
      ST_MUL: begin
        num <= NUM_W'(mag) * NUM_W'(Q88_PER_SECOND);
        den <= {dt, 16'd0} - DEN_W'(dt);
      end
      ST_SAT: begin
        valid_r <= 1'b1;
        if (neg) begin
          vel_r <= div_res.big ? -16'sd32768 : $signed(16'd0 - div_res.quot);
        end else begin
          vel_r <= div_res.big ? 16'sd32767 : $signed(div_res.quot);
        end
      end
      ST_OUT: begin
        velocity_valid <= valid_r;
        velocity       <= vel_r;
        gesture        <= gesture_calc;
      end
      default: begin
        rel_stamp <= rel_stamp;
      end
    endcase
  end

`ifndef SYNTH
  // A result strobe never lasts longer than one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // The walk only ever checks frames that have been written.
  a_walk_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_CK) |-> (walk_idx < fill_level))
    else $error("walk read beyond the filled part of the ring");

  // The fill level saturates at the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(RING_DEPTH))
    else $error("fill level beyond ring depth");

  // An invalid result carries a zero velocity and no gesture.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !velocity_valid) |-> ((velocity == 16'sd0) && (gesture == GEST_NONE)))
    else $error("invalid result with non-zero payload");
`endif

endmodule

### tb/sv/tb_release_swipe_velocity.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Release swipe velocity testbench
// Drives touch frames and key releases through the item channel, tracks the
// frame ring in a software copy and checks every reported swipe velocity and
// gesture class against it, over several register settings.
// ----------------------------------------------------------------------------

import rsv_pkg::*;

typedef struct {
  logic               valid;
  logic signed [15:0] vel;
  logic [1:0]         gest;
} swipe_t;

class swipe_velocity_tracker;
  logic [31:0]        frame_time  [RING_DEPTH];
  logic [15:0]        frame_pos   [RING_DEPTH];
  logic [1:0]         frame_touch [RING_DEPTH];
  int unsigned        wr_slot;
  int unsigned        fill;
  logic [31:0]        lookback;
  logic signed [15:0] up_thr;
  logic signed [15:0] down_thr;
  logic               suspended;
  swipe_t             expected_swipes[$];
  int unsigned        n_frames, n_releases, n_ignored, n_valid, n_up, n_down;
  int unsigned        n_errors;

  function new();
    wr_slot   = 0;
    fill      = 0;
    lookback  = 32'd100000;
    up_thr    = 16'sd256;
    down_thr  = -16'sd384;
    suspended = 1'b0;
  endfunction

  function void write_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_LOOKBACK:  lookback  = value;
      REG_UP_THR:    up_thr    = value[15:0];
      REG_DOWN_THR:  down_thr  = value[15:0];
      REG_SUSPENDED: suspended = value[0];
      default: ;
    endcase
  endfunction

  // Ring slot of the frame that is rank places older than the newest one.
  function int unsigned slot_of(int unsigned rank);
    return (wr_slot + 2 * RING_DEPTH - 1 - rank) % RING_DEPTH;
  endfunction

  function void take_item(logic cmd, logic [31:0] ts, logic [1:0] tc, logic [15:0] pos,
                          logic note);
    int unsigned     rank, end_rank, s_end, s_start;
    bit              seen;
    logic [31:0]     age, dt;
    int              dp;
    longint unsigned mag, quot;
    swipe_t          r;
    if (cmd == CMD_FRAME) begin
      frame_time[wr_slot]  = ts;
      frame_pos[wr_slot]   = pos;
      frame_touch[wr_slot] = tc;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
      if (fill < RING_DEPTH) fill++;
      n_frames++;
      return;
    end
    if (!note) begin
      n_ignored++;
      return;
    end
    n_releases++;
    r.valid = 1'b0;
    r.vel   = 16'sd0;
    r.gest  = GEST_NONE;
    if (fill > 0) begin
      rank     = 0;
      end_rank = 0;
      seen     = 1'b0;
      while (rank < fill) begin
        age = ts - frame_time[slot_of(rank)];
        if (age >= lookback) break;
        if (frame_touch[slot_of(rank)] == 2'd0) begin
          if (seen) begin
            // The frame just after the gap starts the swipe.
            if (rank > 0) rank--;
            break;
          end
        end else if (!seen) begin
          end_rank = rank;
          seen     = 1'b1;
        end
        rank++;
      end
      if (rank >= fill) rank = fill - 1;
      s_end   = slot_of(end_rank);
      s_start = slot_of(rank);
      dt = frame_time[s_end] - frame_time[s_start];
      if (dt != 32'd0) begin
        dp   = int'(frame_pos[s_end]) - int'(frame_pos[s_start]);
        mag  = (dp < 0) ? longint'(-dp) : longint'(dp);
        quot = (mag * 64'(Q88_PER_SECOND)) / (64'(KEY_UNITS) * 64'(dt));
        if (dp < 0) r.vel = (quot >= 64'd32768) ? 16'sh8000 : 16'(64'd0 - quot);
        else        r.vel = (quot >= 64'd32767) ? 16'sh7FFF : 16'(quot);
        r.valid = 1'b1;
        if (!suspended) begin
          if (r.vel > up_thr)        r.gest = GEST_UP;
          else if (r.vel < down_thr) r.gest = GEST_DOWN;
        end
      end
    end
    expected_swipes.push_back(r);
  endfunction

  function void flag(string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  function void check_swipe(logic valid, logic signed [15:0] vel, logic [1:0] gest);
    swipe_t want;
    if (expected_swipes.size() == 0) begin
      flag($sformatf("result with none expected: valid %0b velocity %0d gesture %0d",
                     valid, vel, gest));
      return;
    end
    want = expected_swipes.pop_front();
    if (want.valid) n_valid++;
    if (want.gest == GEST_UP)   n_up++;
    if (want.gest == GEST_DOWN) n_down++;
    if (valid !== want.valid || vel !== want.vel || gest !== want.gest)
      flag($sformatf({"mismatch: valid exp %0b got %0b, velocity exp %0d got %0d, ",
                      "gesture exp %0d got %0d"},
                     want.valid, valid, want.vel, vel, want.gest, gest));
  endfunction

  function void close_out();
    if (expected_swipes.size() != 0)
      flag($sformatf("%0d expected results never arrived", expected_swipes.size()));
  endfunction
endclass

module tb_release_swipe_velocity;

  // Cycles to let a release run to its end when no result marks it; this covers
  // a full ring walk plus the serial divide.
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_LIMIT   = 5000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               command     = CMD_FRAME;
  logic [31:0]        timestamp   = 32'd0;
  logic [1:0]         touch_count = 2'd0;
  logic [15:0]        position    = 16'd0;
  logic               note_active = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = 4'd0;
  logic [31:0]        pwdata      = 32'd0;
  logic               busy;
  logic               done;
  logic               velocity_valid;
  logic signed [15:0] velocity;
  logic [1:0]         gesture;
  logic [31:0]        prdata;
  logic               pready;

  swipe_velocity_tracker tracker;

  // Running microsecond clock of the simulated sensor, and stimulus controls.
  logic [31:0] sensor_us;
  bit          idling_on;
  int unsigned n_counted;
  int unsigned n_settings;

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  release_swipe_velocity uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .timestamp      (timestamp),
    .touch_count    (touch_count),
    .position       (position),
    .note_active    (note_active),
    .done           (done),
    .velocity_valid (velocity_valid),
    .velocity       (velocity),
    .gesture        (gesture),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Results are present for a single cycle and are taken at the edge that
  // closes it; the values seen here are those from before the edge.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_swipe(velocity_valid, velocity, gesture);
  end

  // Lowers start and lets the given number of cycles go by.
  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one item and waits for the edge that accepts it. It is called at
  // a rising edge and returns at one, with start left high so that the next
  // item can follow without a gap. Now and then a short idle burst is added.
  task automatic send_item(logic cmd, logic [31:0] ts, logic [1:0] tc, logic [15:0] pos,
                           logic note);
    start       <= 1'b1;
    command     <= cmd;
    timestamp   <= ts;
    touch_count <= tc;
    position    <= pos;
    note_active <= note;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.take_item(cmd, ts, tc, pos, note);
    if (cmd == CMD_FRAME || note) n_counted++;
    if (idling_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 3));
  endtask

  // Waits until every expected result has arrived and the block has had time
  // to finish a release that reports nothing, so that registers may change.
  task automatic settle();
    start <= 1'b0;
    while (tracker.expected_swipes.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase bus write: a setup phase, then the access phase, which ends at
  // the edge where pready is seen high. The bus then goes idle.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] lb, logic [15:0] up, logic [15:0] dn, logic susp);
    settle();
    write_register(REG_LOOKBACK, lb);
    write_register(REG_UP_THR, {{16{up[15]}}, up});
    write_register(REG_DOWN_THR, {{16{dn[15]}}, dn});
    write_register(REG_SUSPENDED, {31'd0, susp});
    @(posedge clk);
    n_settings++;
  endtask

  // One swipe as a player would make it: a run of frames with a steadily
  // moving position, the odd lifted frame, sometimes a lift just before the
  // end, and then the release (and occasionally a second one).
  task automatic run_swipe();
    int unsigned frames, trail;
    logic [15:0] pos;
    logic [1:0]  tc;
    int          step;
    if ($urandom_range(0, 9) == 0) sensor_us = $urandom();
    frames = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 14);
    trail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    pos    = 16'($urandom());
    step   = int'($urandom_range(0, 8000)) - 4000;
    for (int k = 0; k < int'(frames); k++) begin
      if ($urandom_range(0, 19) != 0) sensor_us = sensor_us + $urandom_range(200, 2500);
      tc  = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      if (k >= int'(frames) - int'(trail)) tc = 2'd0;
      pos = pos + 16'(step + int'($urandom_range(0, 200)) - 100);
      if ($urandom_range(0, 29) == 0) pos = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      send_item(CMD_FRAME, sensor_us, tc, pos, 1'($urandom_range(0, 1)));
    end
    sensor_us = sensor_us + $urandom_range(0, 3000);
    if ($urandom_range(0, 15) == 0) sensor_us = sensor_us + $urandom_range(50000, 300000);
    send_item(CMD_RELEASE, sensor_us, 2'($urandom()), 16'($urandom()),
              1'($urandom_range(0, 9) != 0));
    if ($urandom_range(0, 4) == 0)
      send_item(CMD_RELEASE, sensor_us + $urandom_range(0, 500), 2'($urandom()),
                16'($urandom()), 1'b1);
  endtask

  // Mostly well-formed swipes, with some fully random items mixed in.
  task automatic run_phase(int unsigned count);
    int unsigned target;
    target = n_counted + count;
    while (n_counted < target) begin
      if ($urandom_range(0, 6) == 0)
        send_item(1'($urandom_range(0, 1)), $urandom(), 2'($urandom_range(0, 3)),
                  16'($urandom()), 1'($urandom_range(0, 1)));
      else
        run_swipe();
    end
  endtask

  initial begin
    tracker    = new();
    sensor_us  = 32'd5000;
    idling_on  = 1'b1;
    n_counted  = 0;
    n_settings = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items on the reset register values.
    // A release on an empty ring, and one with the note off.
    send_item(CMD_RELEASE, 32'd0, 2'd0, 16'd0, 1'b1);
    send_item(CMD_RELEASE, 32'd5, 2'd3, 16'hFFFF, 1'b0);
    // A single touch-less frame: no touches seen, start and end coincide.
    send_item(CMD_FRAME, 32'd0, 2'd0, 16'd0, 1'b0);
    send_item(CMD_RELEASE, 32'd10, 2'd0, 16'd0, 1'b1);
    // Full-length swipe downwards in one microsecond: negative saturation.
    send_item(CMD_FRAME, 32'd1000, 2'd3, 16'hFFFF, 1'b1);
    send_item(CMD_FRAME, 32'd1001, 2'd1, 16'h0000, 1'b1);
    send_item(CMD_RELEASE, 32'd1100, 2'd0, 16'd0, 1'b1);
    // A gap, then two touched frames sharing a timestamp: zero time difference.
    send_item(CMD_FRAME, 32'd1002, 2'd0, 16'd1234, 1'b1);
    send_item(CMD_FRAME, 32'd1003, 2'd2, 16'd100, 1'b1);
    send_item(CMD_FRAME, 32'd1003, 2'd1, 16'd200, 1'b1);
    send_item(CMD_RELEASE, 32'd1004, 2'd0, 16'd0, 1'b1);
    // Fast upward swipe back to the gap: positive saturation.
    send_item(CMD_FRAME, 32'd2000, 2'd1, 16'h0000, 1'b0);
    send_item(CMD_FRAME, 32'd2001, 2'd1, 16'hFFFF, 1'b1);
    send_item(CMD_RELEASE, 32'd2001, 2'd0, 16'd0, 1'b1);
    // Finger lifted before the release, then a release long after the
    // newest frame, which is then too old.
    send_item(CMD_FRAME, 32'd2002, 2'd0, 16'd7777, 1'b1);
    send_item(CMD_RELEASE, 32'd2500, 2'd0, 16'd0, 1'b1);
    send_item(CMD_RELEASE, 32'd200000, 2'd0, 16'd0, 1'b1);
    // Timestamps wrapping through zero; the age limit then stops the walk on
    // a touch-less frame, whose stored position is taken as it is.
    send_item(CMD_FRAME, 32'hFFFFFF00, 2'd1, 16'd1000, 1'b1);
    send_item(CMD_FRAME, 32'h00000080, 2'd2, 16'd3000, 1'b1);
    send_item(CMD_RELEASE, 32'h00000100, 2'd0, 16'd0, 1'b1);
    send_item(CMD_RELEASE, 32'hFFFFFFFF, 2'd3, 16'hFFFF, 1'b1);

    // Random phases over a range of register settings.
    configure(32'd100000, 16'd256, 16'hFE80, 1'b0);
    run_phase(180);
    configure(32'd0, 16'h7FFF, 16'h8000, 1'b1);
    run_phase(150);
    configure(32'hFFFFFFFF, 16'h8000, 16'h7FFF, 1'b0);
    run_phase(180);
    configure(32'd5000, 16'd0, 16'd0, 1'b0);
    run_phase(180);
    configure($urandom_range(1000, 200000), 16'($urandom()), 16'($urandom()), 1'b1);
    run_phase(180);
    // Last stretch with no idle cycles at all.
    configure(32'd100000, 16'($urandom_range(0, 2000)), 16'(-int'($urandom_range(0, 2000))),
              1'b0);
    idling_on = 1'b0;
    run_phase(200);

    // Drain the outstanding results, then allow for a silent release.
    start <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && (tracker.expected_swipes.size() != 0 || busy); w++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.close_out();

    $display("Sent %0d frames and %0d releases with the note on (%0d ignored with it off).",
             tracker.n_frames, tracker.n_releases, tracker.n_ignored);
    $display("%0d velocities were valid, %0d up and %0d down gestures, over %0d settings.",
             tracker.n_valid, tracker.n_up, tracker.n_down, n_settings + 1);
    if (tracker.n_errors == 0) $display("PASS release_swipe_velocity");
    else $display("FAIL release_swipe_velocity");
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #5000000;
    $display("FAIL release_swipe_velocity");
    $finish;
  end

endmodule

### files.f
rtl/rsv_pkg.sv
rtl/rsv_ring.sv
rtl/rsv_div.sv
rtl/release_swipe_velocity.sv
tb/sv/tb_release_swipe_velocity.sv
